[sv/assert_macros.svh]
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLSR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clsr checker: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLSR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clsr checker: property failed");

`endif

[sv/clsr_pkg.sv]
// Package: constants, types and arithmetic helpers of the combined LCG generator.
package clsr_pkg;

    localparam int TABLE_SIZE   = 32;
    localparam int WARMUP_EXTRA = 8;
    localparam int WARM_STEPS   = TABLE_SIZE + WARMUP_EXTRA;
    localparam int IDX_W        = $clog2(TABLE_SIZE);
    localparam int CNT_W        = $clog2(WARM_STEPS);
    localparam int VAL_W        = 31;
    localparam int MUL_W        = 16;
    localparam int PROD_W       = VAL_W + MUL_W;

    localparam logic [VAL_W-1:0] MOD_ONE   = 31'd2147483563;
    localparam logic [VAL_W-1:0] MOD_TWO   = 31'd2147483399;
    localparam logic [MUL_W-1:0] MUL_ONE   = 16'd40014;
    localparam logic [MUL_W-1:0] MUL_TWO   = 16'd40692;
    localparam logic [VAL_W-1:0] TOP_VALUE = 31'd2147483562;
    localparam logic [VAL_W-1:0] ONE_VALUE = 31'd1;

    // 2^31 is congruent to these small gaps under each modulus
    localparam logic [7:0] GAP_ONE = 8'd85;
    localparam logic [7:0] GAP_TWO = 8'd249;

    // Table slot span: 1 + TOP / TABLE_SIZE, just under a power of two
    localparam int SLOT_SPAN  = 1 + 2147483562 / TABLE_SIZE;
    localparam int SLOT_SHIFT = $clog2(SLOT_SPAN);
    localparam int SLOT_GAP   = (1 << SLOT_SHIFT) - SLOT_SPAN;
    localparam int REM_W      = SLOT_SHIFT + 2;

    localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'(WARM_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_WARM_MUL,
        ST_WARM_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;     // input word taken this cycle
        logic load_seed;   // both generators take the seed
        logic mul;         // register both products
        logic warm_step;   // warm-up step of the first generator
        logic draw_commit; // finish a draw and load the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic seeded;
        logic count_zero;
    } status_t;

    // Fold a product modulo 2^31 - 85: hi*2^31 + lo == hi*85 + lo
    function automatic logic [VAL_W-1:0] fold_one(input logic [PROD_W-1:0] prod);
        logic [VAL_W:0] sum;
        sum = {1'b0, prod[VAL_W-1:0]}
            + (VAL_W+1)'(prod[PROD_W-1:VAL_W]) * (VAL_W+1)'(GAP_ONE);
        if (sum >= {1'b0, MOD_ONE})
            sum = sum - {1'b0, MOD_ONE};
        return sum[VAL_W-1:0];
    endfunction

    // Fold a product modulo 2^31 - 249
    function automatic logic [VAL_W-1:0] fold_two(input logic [PROD_W-1:0] prod);
        logic [VAL_W:0] sum;
        sum = {1'b0, prod[VAL_W-1:0]}
            + (VAL_W+1)'(prod[PROD_W-1:VAL_W]) * (VAL_W+1)'(GAP_TWO);
        if (sum >= {1'b0, MOD_TWO})
            sum = sum - {1'b0, MOD_TWO};
        return sum[VAL_W-1:0];
    endfunction

    // Seed reduction: wrap once, zero becomes one
    function automatic logic [VAL_W-1:0] reduce_seed(input logic [VAL_W-1:0] s);
        logic [VAL_W-1:0] r;
        r = (s >= MOD_ONE) ? (s - MOD_ONE) : s;
        if (r == '0)
            r = ONE_VALUE;
        return r;
    endfunction

    // Slot = last / SLOT_SPAN: shift estimate, one correction, clamp
    function automatic logic [IDX_W-1:0] slot_of(input logic [VAL_W-1:0] last);
        logic [IDX_W:0]   q;
        logic [REM_W-1:0] rem;
        q   = (IDX_W+1)'(last >> SLOT_SHIFT);
        rem = REM_W'(last[SLOT_SHIFT-1:0]) + REM_W'(q * SLOT_GAP);
        if (rem >= REM_W'(SLOT_SPAN))
            q = q + 1'b1;
        if (q >= (IDX_W+1)'(TABLE_SIZE))
            q = (IDX_W+1)'(TABLE_SIZE - 1);
        return q[IDX_W-1:0];
    endfunction

endpackage

[sv/clsr_ctrl.sv]
// Controller: sequences seeding, warm-up and draws, owns the output valid flag.
module clsr_ctrl
    import clsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    kind,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    state_t start_state;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // First state of a newly accepted word
    assign start_state = (kind || !status.seeded) ? ST_SEED : ST_DRAW_MUL;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = start_state;
            end
            ST_SEED:     state_next = ST_WARM_MUL;
            ST_WARM_MUL: state_next = ST_WARM_RED;
            ST_WARM_RED:
            begin
                state_next = status.count_zero ? ST_DRAW_MUL : ST_WARM_MUL;
            end
            ST_DRAW_MUL: state_next = ST_DRAW_RED;
            ST_DRAW_RED:
            begin
                if (out_free)
                    state_next = in_valid ? start_state : ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:     in_ready = 1'b1;
            ST_SEED:     cmd.load_seed = 1'b1;
            ST_WARM_MUL: cmd.mul = 1'b1;
            ST_WARM_RED: cmd.warm_step = 1'b1;
            ST_DRAW_MUL: cmd.mul = 1'b1;
            ST_DRAW_RED:
            begin
                in_ready        = out_free;
                cmd.draw_commit = out_free;
            end
            default:     in_ready = 1'b0;
        endcase
        cmd.capture = in_valid && in_ready;
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.draw_commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/clsr_datapath.sv]
// Datapath: both generators, modular multipliers, shuffle table and output word.
module clsr_datapath
    import clsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic             kind,
    input  logic [VAL_W-1:0] seed,
    output status_t          status,
    output logic [VAL_W-1:0] value
);

    logic [VAL_W-1:0]  first_reg, first_next;
    logic [VAL_W-1:0]  second_reg, second_next;
    logic [VAL_W-1:0]  last_reg, last_next;
    logic [VAL_W-1:0]  seed_reg, seed_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [PROD_W-1:0] prod1_reg, prod2_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [VAL_W-1:0]  table_reg [TABLE_SIZE];

    logic [VAL_W-1:0]  red1, red2;
    logic [IDX_W-1:0]  slot;
    logic [VAL_W-1:0]  entry;
    logic [VAL_W-1:0]  draw_val;
    logic [VAL_W:0]    wide_diff;

    // Reduction of the registered products
    assign red1 = fold_one(prod1_reg);
    assign red2 = fold_two(prod2_reg);

    // Shuffle slot and combined deviate
    assign slot  = slot_of(last_reg);
    assign entry = table_reg[slot];

    always_comb
    begin
        if (entry <= red2)
            wide_diff = {1'b0, entry} + {1'b0, TOP_VALUE} - {1'b0, red2};
        else
            wide_diff = {1'b0, entry} - {1'b0, red2};
        draw_val = wide_diff[VAL_W-1:0];
    end

    // Next values of the generator state
    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        last_next   = last_reg;
        seed_next   = seed_reg;
        value_next  = value_reg;
        count_next  = count_reg;

        if (cmd.capture)
            seed_next = kind ? reduce_seed(seed) : ONE_VALUE;

        if (cmd.load_seed)
        begin
            first_next  = seed_reg;
            second_next = seed_reg;
            count_next  = WARM_LAST;
        end

        if (cmd.warm_step)
        begin
            first_next = red1;
            if (count_reg == '0)
                last_next = red1;
            else
                count_next = count_reg - 1'b1;
        end

        if (cmd.draw_commit)
        begin
            first_next  = red1;
            second_next = red2;
            last_next   = draw_val;
            value_next  = draw_val;
        end
    end

    // Generator state, products and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= 31'd123456789;
            last_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            last_reg   <= last_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg  <= seed_next;
        value_reg <= value_next;
        if (cmd.mul)
        begin
            prod1_reg <= PROD_W'(first_reg) * PROD_W'(MUL_ONE);
            prod2_reg <= PROD_W'(second_reg) * PROD_W'(MUL_TWO);
        end
    end

    // Shuffle table: filled by warm-up, one entry replaced per draw
    always_ff @(posedge clk)
    begin
        if (cmd.warm_step && (count_reg < CNT_W'(TABLE_SIZE)))
            table_reg[count_reg[IDX_W-1:0]] <= red1;
        else if (cmd.draw_commit)
            table_reg[slot] <= red1;
    end

    assign status.seeded     = (first_reg != '0);
    assign status.count_zero = (count_reg == '0);
    assign value             = value_reg;

endmodule

[sv/combined_lcg_shuffle_rng.sv]
// Draw: an accepted word is multiplied, then folded, shuffled and loaded into the output word.
// Draws do not overlap: a new word is taken only while idle or as a result is loaded.
// Reseed, or first draw after reset: a seed load, then 40 warm-up steps (multiply, fold)
// of the first generator, then the draw.
// Reset (rst_n, asynchronous, active low) clears control and marks the block unseeded;
// the shuffle table needs no clearing because the first word always reseeds.
module combined_lcg_shuffle_rng
    import clsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic [VAL_W-1:0] seed,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [VAL_W-1:0] value
);

    cmd_t    cmd;
    status_t status;

    // Sequencer
    clsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and storage
    clsr_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .kind   (kind),
        .seed   (seed),
        .status (status),
        .value  (value)
    );

endmodule

[sv/clsr_checker.sv]
// Port-level checker for the combined LCG generator, bound to the top level.
`include "assert_macros.svh"

module clsr_checker
    import clsr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [VAL_W-1:0] value
);

    // A stalled result word holds
    `CLSR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value))

    // Every deviate lies in 1..TOP
    `CLSR_ASSERT_IMP(a_range, clk, rst_n, out_valid, (value != '0) && (value <= TOP_VALUE))

    // The block is busy right after taking a word
    `CLSR_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)

    // A new result needs the multiply and fold cycles first
    `CLSR_ASSERT_IMP(a_latency, clk, rst_n, in_valid && in_ready, ##2 !$rose(out_valid))

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (.*);
